// File: hdl/sram_slv_pkg.sv
package sram_slv_pkg;

   // memory geometry
   localparam int ADDR_BITS     = 16;
   localparam int ADDR_BYTES    = (ADDR_BITS + 7) / 8;
   localparam int ADDR_CNT_BITS = (ADDR_BYTES > 1) ? $clog2(ADDR_BYTES) : 1;
   localparam int MEM_DEPTH     = 1 << ADDR_BITS;

   // command bytes
   localparam logic [7:0] CMD_READ  = 8'h03;
   localparam logic [7:0] CMD_WRITE = 8'h02;

   // queue between front and back
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic       func;
      logic [7:0] mosi_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] miso_byte;
      logic       data_phase;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } op_kind_type;

   typedef struct packed {
      op_kind_type          kind;
      logic [ADDR_BITS-1:0] addr;
      logic [7:0]           data;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: hdl/sram_slv_front.sv
module sram_slv_front import sram_slv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_accept,
   input  req_type req_word,
   output op_type  op_word,
   output logic    op_push
);

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_ADDR   = 4'b0010,
      PH_DATA   = 4'b0100,
      PH_IGNORE = 4'b1000
   } phase_type;

   phase_type              phase_ff, phase_in;
   op_kind_type            kind_ff, kind_in;
   logic [ADDR_BITS-1:0]   ptr_ff, ptr_in;
   logic [ADDR_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [ADDR_BITS+7:0]   shift_word;

   assign shift_word = {ptr_ff, req_word.mosi_byte};
   assign op_push    = req_accept;

   always_comb begin
      phase_in     = phase_ff;
      kind_in      = kind_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      op_word.kind = OP_NONE;
      op_word.addr = ptr_ff;
      op_word.data = req_word.mosi_byte;
      if (req_word.func) begin
         phase_in = PH_IDLE;
         kind_in  = OP_NONE;
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (req_word.mosi_byte == CMD_READ) begin
                  kind_in  = OP_READ;
                  ptr_in   = '0;
                  cnt_in   = '0;
                  phase_in = PH_ADDR;
               end else if (req_word.mosi_byte == CMD_WRITE) begin
                  kind_in  = OP_WRITE;
                  ptr_in   = '0;
                  cnt_in   = '0;
                  phase_in = PH_ADDR;
               end else begin
                  kind_in  = OP_NONE;
                  phase_in = PH_IGNORE;
               end
            end
            PH_ADDR: begin
               ptr_in = shift_word[ADDR_BITS-1:0];
               if (cnt_ff == ADDR_CNT_BITS'(ADDR_BYTES - 1)) begin
                  phase_in = PH_DATA;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            PH_DATA: begin
               op_word.kind = kind_ff;
               ptr_in       = ptr_ff + 1'b1;
            end
            PH_IGNORE: begin
            end
            default: begin
               phase_in = PH_IDLE;
               kind_in  = OP_NONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         kind_ff  <= OP_NONE;
         ptr_ff   <= '0;
         cnt_ff   <= '0;
      end else if (req_accept) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         ptr_ff   <= ptr_in;
         cnt_ff   <= cnt_in;
      end
   end

   // a release always lands back in idle with no command
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_word.func |=> phase_ff == PH_IDLE && kind_ff == OP_NONE)
      else $error("release did not return to idle");

endmodule

// File: hdl/sram_slv_queue.sv
module sram_slv_queue import sram_slv_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  op_type           push_word,
   input  logic             pop,
   output op_type           head_word,
   output queue_status_type status
);

   op_type                    entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   assign head_word    = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !status.full)
      else $error("push into a full queue");

   assert property (@(posedge clock) disable iff (reset) pop |-> !status.empty)
      else $error("pop from an empty queue");

endmodule

// File: hdl/sram_slv_back.sv
module sram_slv_back import sram_slv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  op_type  op_word,
   input  logic    op_valid,
   output logic    op_pop,
   output rsp_type rsp_word,
   output logic    rsp_strobe
);

   logic [7:0] mem [MEM_DEPTH];
   logic [7:0] rdata_ff;
   logic       strobe_ff;
   logic       dp_ff;
   logic       rd_ff;

   // one operation per cycle, no back-pressure from the receiver
   assign op_pop = op_valid;

   always_ff @(posedge clock) begin
      if (op_pop && op_word.kind == OP_WRITE) begin
         mem[op_word.addr] <= op_word.data;
      end
      if (op_pop && op_word.kind == OP_READ) begin
         rdata_ff <= mem[op_word.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
         dp_ff     <= 1'b0;
         rd_ff     <= 1'b0;
      end else begin
         strobe_ff <= op_pop;
         dp_ff     <= op_pop && (op_word.kind != OP_NONE);
         rd_ff     <= op_pop && (op_word.kind == OP_READ);
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_word.miso_byte  = rd_ff ? rdata_ff : 8'd0;
   assign rsp_word.data_phase = dp_ff;

   assert property (@(posedge clock) disable iff (reset) op_pop |=> strobe_ff)
      else $error("popped operation gave no result");

   assert property (@(posedge clock) disable iff (reset)
      op_pop && op_word.kind == OP_NONE |=> !dp_ff && !rd_ff)
      else $error("non-data byte flagged as data");

endmodule

// File: hdl/spi_sram_slave_unit.sv
// channel   ports                          direction  handshake
// request   start, busy, req_word          in         taken when start and not busy
// response  rsp_strobe, rsp_word           out        one cycle per word, never held off
//
// one word accepted per cycle at most, back to back included
// its response reaches the ports after the queue entry register and then the registered read
// of the byte memory and the result strobe registers in the back part
// the back pops a word every cycle, so the two-entry queue never fills and busy stays low
// synchronous reset clears the phase, command, pointer, queue and strobe; memory is left as is
// the receiver cannot stall, so results leave in strict acceptance order
module spi_sram_slave_unit import sram_slv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_strobe,
   output rsp_type rsp_word
);

   logic             req_accept;
   op_type           front_word;
   logic             front_push;
   op_type           head_word;
   logic             back_pop;
   queue_status_type q_status;

   // word handshake
   assign busy       = q_status.full;
   assign req_accept = start && !busy;

   // front: command decode, address assembly, pointer increment
   sram_slv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_word   (req_word),
      .op_word    (front_word),
      .op_push    (front_push)
   );

   // decoupling queue of classified operations
   sram_slv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_word (front_word),
      .pop       (back_pop),
      .head_word (head_word),
      .status    (q_status)
   );

   // back: memory access and response formatting
   sram_slv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .op_word    (head_word),
      .op_valid   (!q_status.empty),
      .op_pop     (back_pop),
      .rsp_word   (rsp_word),
      .rsp_strobe (rsp_strobe)
   );

endmodule

// File: dv/spi_sram_slave_checker.sv
module spi_sram_slave_checker import sram_slv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_word,
   input  logic    rsp_strobe,
   input  rsp_type rsp_word,
   output int      mismatch_count,
   output int      pending_count
);

   localparam int REPORT_LIMIT = 10;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADDR,
      ST_DATA,
      ST_IGNORE
   } slave_phase_type;

   // shadow of the slave
   slave_phase_type      phase_now = ST_IDLE;
   op_kind_type          cmd_kind  = OP_NONE;
   logic [ADDR_BITS-1:0] addr_ptr  = '0;
   int                   addr_seen = 0;
   logic [7:0]           mem_image [MEM_DEPTH];

   rsp_type              expected_q [$];
   int                   fault_total = 0;

   // one byte exchange or release through the shadow, giving the word it answers
   function automatic rsp_type step_slave(req_type w);
      rsp_type r;
      r.miso_byte  = 8'h00;
      r.data_phase = 1'b0;
      if (w.func) begin
         phase_now = ST_IDLE;
         cmd_kind  = OP_NONE;
      end else begin
         case (phase_now)
            ST_IDLE: begin
               if (w.mosi_byte == CMD_READ || w.mosi_byte == CMD_WRITE) begin
                  cmd_kind  = (w.mosi_byte == CMD_READ) ? OP_READ : OP_WRITE;
                  addr_ptr  = '0;
                  addr_seen = 0;
                  phase_now = ST_ADDR;
               end else begin
                  cmd_kind  = OP_NONE;
                  phase_now = ST_IGNORE;
               end
            end
            ST_ADDR: begin
               addr_ptr  = (addr_ptr << 8) | ADDR_BITS'(w.mosi_byte);
               addr_seen = addr_seen + 1;
               if (addr_seen == ADDR_BYTES)
                  phase_now = ST_DATA;
            end
            ST_DATA: begin
               if (cmd_kind == OP_READ)
                  r.miso_byte = mem_image[addr_ptr];
               else
                  mem_image[addr_ptr] = w.mosi_byte;
               r.data_phase = 1'b1;
               addr_ptr     = addr_ptr + 1'b1;
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   task automatic note_fault(input string what, input logic [8:0] want_v,
                             input logic [8:0] got_v);
      fault_total = fault_total + 1;
      if (fault_total <= REPORT_LIMIT)
         $display("checker: %s mismatch, expected %0h got %0h", what, want_v, got_v);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         phase_now = ST_IDLE;
         cmd_kind  = OP_NONE;
         addr_ptr  = '0;
         addr_seen = 0;
         expected_q.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_q.size() == 0) begin
               note_fault("unexpected word", 9'h000, rsp_word);
            end else begin
               want = expected_q.pop_front();
               if (rsp_word.miso_byte !== want.miso_byte)
                  note_fault("miso_byte", 9'(want.miso_byte), 9'(rsp_word.miso_byte));
               if (rsp_word.data_phase !== want.data_phase)
                  note_fault("data_phase", 9'(want.data_phase), 9'(rsp_word.data_phase));
            end
         end
         if (start && !busy)
            expected_q.push_back(step_slave(req_word));
      end
      pending_count  <= expected_q.size();
      mismatch_count <= fault_total;
   end

endmodule

// File: dv/spi_sram_slave_unit_tb.sv
module spi_sram_slave_unit_tb;
   import sram_slv_pkg::*;

   localparam int STALL_LIMIT   = 500;   // cycles with no word moving before giving up
   localparam int SETTLE_CYCLES = 8;
   localparam int ITEM_TARGET   = 1350;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_strobe;
   rsp_type rsp_word;
   int      mismatch_count;
   int      pending_count;
   int      idle_cycles = 0;

   // stimulus-side view of the slave, kept only so that no read ever lands
   // on a byte that has not been written yet
   bit                   written_map [MEM_DEPTH];
   logic [ADDR_BITS-1:0] write_starts [$];
   bit                   trk_active    = 1'b0;
   op_kind_type          trk_kind      = OP_NONE;
   int                   trk_addr_left = 0;
   logic [ADDR_BITS-1:0] trk_ptr       = '0;

   bit                   no_idle    = 1'b0;  // burst with no gaps between words
   int                   sent_count = 0;

   spi_sram_slave_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   spi_sram_slave_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_word       (req_word),
      .rsp_strobe     (rsp_strobe),
      .rsp_word       (rsp_word),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: a long stretch with no word taken and none returned means a hang
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("spi_sram_slave_unit_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // hand one word to the slave and wait for it to be taken
   // start stays high across back-to-back words, it only drops for a gap
   task automatic send_word(input logic rel, input logic [7:0] b);
      int gap;
      // a read of an unwritten byte is turned into a release
      if (!rel && trk_active && trk_kind == OP_READ && trk_addr_left == 0
          && !written_map[trk_ptr])
         rel = 1'b1;

      // follow the command sequence on the stimulus side
      if (rel) begin
         trk_active = 1'b0;
         trk_kind   = OP_NONE;
      end else if (!trk_active) begin
         trk_active = 1'b1;
         if (b == CMD_READ || b == CMD_WRITE) begin
            trk_kind      = (b == CMD_READ) ? OP_READ : OP_WRITE;
            trk_ptr       = '0;
            trk_addr_left = ADDR_BYTES;
         end else begin
            trk_kind      = OP_NONE;
            trk_addr_left = 0;
         end
      end else if (trk_kind != OP_NONE && trk_addr_left > 0) begin
         trk_ptr       = (trk_ptr << 8) | ADDR_BITS'(b);
         trk_addr_left = trk_addr_left - 1;
      end else if (trk_kind != OP_NONE) begin
         if (trk_kind == OP_WRITE)
            written_map[trk_ptr] = 1'b1;
         trk_ptr = trk_ptr + 1'b1;
      end

      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= '{func: rel, mosi_byte: b};
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_count++;
   endtask

   // address bytes, most significant first
   task automatic send_address(input logic [ADDR_BITS-1:0] addr);
      for (int i = 0; i < ADDR_BYTES; i++)
         send_word(1'b0, 8'(addr >> (8 * (ADDR_BYTES - 1 - i))));
   endtask

   initial begin
      logic [ADDR_BITS-1:0] base;
      logic [ADDR_BITS-1:0] near_top;
      int                   choice;
      int                   len;

      near_top = {ADDR_BITS{1'b1}} - 1'b1;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // write across the top of memory so the pointer wraps to zero
      send_word(1'b0, CMD_WRITE);
      send_address(near_top);
      send_word(1'b0, 8'h00);
      send_word(1'b0, 8'hFF);
      send_word(1'b0, 8'hA5);
      send_word(1'b1, 8'h00);
      write_starts.push_back(near_top);

      // read the same bytes back, wrap included, with junk on mosi
      send_word(1'b0, CMD_READ);
      send_address(near_top);
      send_word(1'b0, 8'hFF);
      send_word(1'b0, 8'h00);
      send_word(1'b0, 8'h5A);
      send_word(1'b1, 8'hFF);

      // unknown commands: later command-like bytes are ignored until release
      send_word(1'b0, 8'h00);
      send_word(1'b0, CMD_READ);
      send_word(1'b0, CMD_WRITE);
      send_word(1'b1, 8'h00);
      send_word(1'b0, 8'hFF);
      send_word(1'b0, 8'h55);
      send_word(1'b1, 8'hFF);

      // release in the middle of an address, then a release while idle
      send_word(1'b0, CMD_WRITE);
      send_word(1'b0, 8'h12);
      send_word(1'b1, 8'h00);
      send_word(1'b1, 8'h81);

      // --- random part ---
      while (sent_count < ITEM_TARGET) begin
         no_idle = ($urandom_range(0, 3) == 0);
         choice  = $urandom_range(0, 99);
         if (choice < 45 || write_starts.size() == 0) begin
            // write burst, now and then close to the top for wrapping
            if ($urandom_range(0, 7) == 0)
               base = {ADDR_BITS{1'b1}} - ADDR_BITS'($urandom_range(0, 15));
            else
               base = ADDR_BITS'($urandom);
            len = $urandom_range(0, 16);
            send_word(1'b0, CMD_WRITE);
            send_address(base);
            repeat (len) send_word(1'b0, 8'($urandom));
            send_word(1'b1, 8'($urandom));
            write_starts.push_back(base);
         end else if (choice < 80) begin
            // read burst from a place that has been written, stopping at a hole
            base = write_starts[$urandom_range(0, write_starts.size() - 1)];
            len  = $urandom_range(1, 16);
            send_word(1'b0, CMD_READ);
            send_address(base);
            for (int i = 0; i < len && written_map[trk_ptr]; i++)
               send_word(1'b0, 8'($urandom));
            send_word(1'b1, 8'($urandom));
         end else if (choice < 90) begin
            // command cut short during or right after the address
            send_word(1'b0, $urandom_range(0, 1) ? CMD_READ : CMD_WRITE);
            repeat ($urandom_range(0, ADDR_BYTES)) send_word(1'b0, 8'($urandom));
            send_word(1'b1, 8'($urandom));
         end else begin
            // raw noise: stray bytes and releases
            repeat ($urandom_range(1, 8))
               send_word($urandom_range(0, 3) == 0, 8'($urandom));
            send_word(1'b1, 8'($urandom));
         end
      end

      start <= 1'b0;

      // drain, then give any stray word time to show up
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("spi_sram_slave_unit_tb: done, clean");
      else
         $display("spi_sram_slave_unit_tb: done, errors");
      $finish;
   end

endmodule
